### rtl/iiel_pkg.sv
// Shared types and constants for the indexed insert/erase list.
package iiel_pkg;

    localparam int DATA_W      = 32;
    localparam int ACT_W       = 3;
    localparam int POS_W       = 7;
    localparam int STAT_W      = 2;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_INSERT     = 3'd1,
        ACT_POP_LAST   = 3'd2,
        ACT_POP_FIRST  = 3'd3,
        ACT_ERASE      = 3'd4,
        ACT_READ       = 3'd5
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD = 2'd0,
        SHIFT_UP   = 2'd1,
        SHIFT_DOWN = 2'd2
    } shift_op_t;

    typedef struct packed {
        shift_op_t                 op;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

### rtl/iiel_cell.sv
// One storage cell of the list: holds a word, shifts with its neighbours.
module iiel_cell
    import iiel_pkg::*;
#(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
)
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic [IDX_W-1:0]         sel,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0] pick
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit;
    logic                     above;

    assign hit   = (sel == IDX_W'(CELL_IDX));
    assign above = (IDX_W'(CELL_IDX) > sel);

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            SHIFT_UP:
            begin
                if (hit)
                begin
                    data_next = cmd.value;
                end
                else if (above)
                begin
                    data_next = left_data;
                end
            end
            SHIFT_DOWN:
            begin
                if (hit || above)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign pick = hit ? data_reg : '0;

endmodule

### rtl/indexed_insert_erase_list.sv
// Top level of the indexed insert/erase list: request decode, count and result register.
//
// Holds an ordered list of up to CAPACITY signed 32-bit words in a row of cells.
// Request channel: action, position and new_value are taken at a rising edge with
// start high and busy low. busy is held low: every cell shifts in parallel with its
// neighbours, so a request of any kind completes without a stall and a new item may be
// presented in every cycle.
// Result channel: done is high for exactly one cycle, the cycle after the request
// was taken, with status, count_after and element_out valid in that cycle. The
// receiver cannot stall the block; a result not taken in that cycle is lost.
// Throughput is one item per cycle; the selected word for a read, pop or erase comes
// through an AND-OR select over all cells ahead of the result register.
// Reset (rst_n low, asynchronous) empties the list and clears done. Stored words
// are not cleared; only positions below the count are ever read.
// status: 0 done, 1 position out of range, 2 list empty, 3 list full. A refused
// request leaves the list unchanged and returns element_out as zero.
module indexed_insert_erase_list
    import iiel_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ACT_W-1:0]         action,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] new_value,
    output logic                     done,
    output logic [STAT_W-1:0]        status,
    output logic [COUNT_OUT_W-1:0]   count_after,
    output logic signed [DATA_W-1:0] element_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    status_t                   status_reg;
    status_t                   status_next;
    logic [COUNT_OUT_W-1:0]    count_after_reg;
    logic signed [DATA_W-1:0]  element_reg;
    logic signed [DATA_W-1:0]  element_next;

    cell_cmd_t                 cmd;
    logic [IDX_W-1:0]          sel;
    logic                      take;
    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [CMP_W-1:0]          pos_cmp;
    logic [CMP_W-1:0]          cnt_cmp;
    logic signed [DATA_W-1:0]  picked;

    logic signed [DATA_W-1:0]  cell_data [CAPACITY];
    logic signed [DATA_W-1:0]  cell_pick [CAPACITY];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_cmp = CMP_W'(position);
    assign cnt_cmp = CMP_W'(count_reg);

    always_comb
    begin
        status_next = ST_DONE;
        count_next  = count_reg;
        cmd.op      = SHIFT_HOLD;
        cmd.value   = new_value;
        sel         = '0;
        take        = 1'b0;
        if (accept)
        begin
            case (action_t'(action))
                ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = SHIFT_UP;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_INSERT:
                begin
                    if (pos_cmp > cnt_cmp)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = SHIFT_UP;
                        sel        = IDX_W'(position);
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_POP_LAST:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        sel        = IDX_W'(count_reg - 1'b1);
                        take       = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                ACT_POP_FIRST:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.op     = SHIFT_DOWN;
                        take       = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                ACT_ERASE:
                begin
                    if (pos_cmp >= cnt_cmp)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        cmd.op     = SHIFT_DOWN;
                        sel        = IDX_W'(position);
                        take       = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                ACT_READ:
                begin
                    if (pos_cmp >= cnt_cmp)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        sel  = IDX_W'(position);
                        take = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic signed [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cell_data[i];
        end
        else
        begin : g_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_right
            assign right_data = cell_data[i+1];
        end

        iiel_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .sel        (sel),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .pick       (cell_pick[i])
        );
    end

    always_comb
    begin
        picked = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            picked = picked | cell_pick[i];
        end
    end

    assign element_next = take ? picked : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            count_after_reg <= COUNT_OUT_W'(count_next);
            element_reg     <= element_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign count_after = count_after_reg;
    assign element_out = element_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result missing one cycle after request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without request");

    a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count_after == COUNT_OUT_W'(count_reg)))
        else $error("reported count differs from held count");

    a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_DONE)) |-> ($stable(count_reg) && (element_out == '0)))
        else $error("refused request changed count or returned data");
`endif

endmodule
